// ===== src/tcps_pkg.sv =====
// Shared types and constants for the three-class priority scheduler store.
package tcps_pkg;

    localparam int HANDLE_W = 16;
    localparam int PRIO_W   = 32;
    localparam int STAMP_W  = 32;
    localparam int KIND_W   = 2;
    localparam int OUT_OCC_W = 5;

    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEFAULT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NOPIO   = 2'd3;

    localparam logic CLASS_STD  = 1'b0;
    localparam logic CLASS_NOIO = 1'b1;

    typedef enum logic [1:0] {
        FUNC_PUSH_READY   = 2'd0,
        FUNC_PUSH_RESCHED = 2'd1,
        FUNC_TAKE         = 2'd2,
        FUNC_FLUSH        = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_MOVE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [KIND_W-1:0]   kind;
        logic [PRIO_W-1:0]   prio;
        logic [STAMP_W-1:0]  stamp;
    } t_entry;

    typedef struct packed {
        logic step;
        logic first;
    } t_pick_ctl;

endpackage

// ===== src/tcps_pick.sv =====
// Running best-entry selector fed one stored entry per cycle during a take scan.
module tcps_pick
    import tcps_pkg::*;
#(
    parameter int IDX_W = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_pick_ctl           i_ctl,
    input  t_entry              i_entry,
    input  logic [IDX_W-1:0]    i_idx,
    input  logic [STAMP_W-1:0]  i_arrival,
    output t_entry              o_best,
    output logic [IDX_W-1:0]    o_best_idx
);

    t_entry             r_best;
    logic [STAMP_W-1:0] r_best_age;
    logic [IDX_W-1:0]   r_best_idx;
    logic [STAMP_W-1:0] cand_age;
    logic               cand_better;

    assign cand_age = i_arrival - i_entry.stamp;

    always_comb begin
        if (i_entry.kind != r_best.kind) begin
            cand_better = (i_entry.kind < r_best.kind);
        end else if (i_entry.kind != KIND_READY && i_entry.prio != r_best.prio) begin
            cand_better = (i_entry.prio < r_best.prio);
        end else begin
            cand_better = (cand_age > r_best_age);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_idx <= '0;
        end else if (i_ctl.step && (i_ctl.first || cand_better)) begin
            r_best_idx <= i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step && (i_ctl.first || cand_better)) begin
            r_best     <= i_entry;
            r_best_age <= cand_age;
        end
    end

    assign o_best     = r_best;
    assign o_best_idx = r_best_idx;

endmodule

// ===== src/three_class_priority_fifo_scheduler_core.sv =====
// Top level of the three-class priority scheduler store with its entry memory.
//
// Stored handles sit packed in slots 0 to occupancy-1 of a one-read, one-write entry
// memory with registered read data. Each word gets exactly one result word. A push or
// a flush passes through the execute and done states before its result is loaded into
// the output register; a take on a non-empty store reads each stored entry once to
// find the winner, then does one read and write that moves the last entry into the
// freed slot, and a take on an empty store goes from execute straight to done. A
// stalled output register that still holds a result adds its stall cycles before
// the next result is loaded.
// One word is worked on at a time; the next word is accepted while a finished result
// still waits in the output register. No clearing pass runs after reset.
module three_class_priority_fifo_scheduler_core
    import tcps_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_func,
    input  logic [HANDLE_W-1:0]   i_handle_id,
    input  logic                  i_queue_class,
    input  logic [PRIO_W-1:0]     i_prio_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_served,
    output logic [HANDLE_W-1:0]   o_served_handle,
    output logic [KIND_W-1:0]     o_served_source,
    output logic                  o_push_rejected,
    output logic [OUT_OCC_W-1:0]  o_occupancy
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int OCC_W = $clog2(CAPACITY + 1);

    t_state               r_state;
    t_state               n_state;
    t_func                r_func;
    logic [HANDLE_W-1:0]  r_handle;
    logic                 r_class;
    logic [PRIO_W-1:0]    r_prio;
    logic [OCC_W-1:0]     r_occ;
    logic [STAMP_W-1:0]   r_arrival;
    logic [IDX_W-1:0]     r_idx;

    logic                 r_res_served;
    logic [HANDLE_W-1:0]  r_res_handle;
    logic [KIND_W-1:0]    r_res_source;
    logic                 r_res_rejected;

    logic                 r_out_valid;
    logic                 r_served;
    logic [HANDLE_W-1:0]  r_served_handle;
    logic [KIND_W-1:0]    r_served_source;
    logic                 r_push_rejected;
    logic [OUT_OCC_W-1:0] r_occupancy;

    t_entry               r_mem [CAPACITY];
    t_entry               r_rd_data;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_wa;
    t_entry               mem_wd;
    logic [IDX_W-1:0]     mem_ra;
    t_pick_ctl            pick_ctl;
    logic                 out_load;
    logic                 in_stall;

    logic [OCC_W-1:0]     occ_m1;
    logic                 occ_full;
    logic                 occ_empty;
    logic                 scan_last;
    logic [OCC_W+OUT_OCC_W-1:0] occ_ext;
    t_entry               push_entry;
    t_entry               best;
    logic [IDX_W-1:0]     best_idx;

    assign occ_m1    = r_occ - OCC_W'(1);
    assign occ_full  = (r_occ == OCC_W'(CAPACITY));
    assign occ_empty = (r_occ == '0);
    assign scan_last = (OCC_W'(r_idx) == occ_m1);
    assign occ_ext   = {{OUT_OCC_W{1'b0}}, r_occ};

    always_comb begin
        push_entry.handle = r_handle;
        push_entry.stamp  = r_arrival;
        if (r_func == FUNC_PUSH_READY) begin
            push_entry.kind = KIND_READY;
            push_entry.prio = '0;
        end else begin
            push_entry.kind = (r_class == CLASS_STD) ? KIND_DEFAULT : KIND_NOPIO;
            push_entry.prio = r_prio;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_func == FUNC_TAKE && !occ_empty) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_MOVE;
                end
            end
            ST_MOVE: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_stall       = 1'b1;
        mem_we         = 1'b0;
        mem_wa         = best_idx;
        mem_wd         = r_rd_data;
        mem_ra         = '0;
        pick_ctl.step  = 1'b0;
        pick_ctl.first = 1'b0;
        out_load       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                in_stall = 1'b0;
            end
            ST_EXEC: begin
                if ((r_func == FUNC_PUSH_READY || r_func == FUNC_PUSH_RESCHED) && !occ_full)
                begin
                    mem_we = 1'b1;
                    mem_wa = r_occ[IDX_W-1:0];
                    mem_wd = push_entry;
                end
            end
            ST_SCAN: begin
                pick_ctl.step  = 1'b1;
                pick_ctl.first = (r_idx == '0);
                mem_ra = scan_last ? occ_m1[IDX_W-1:0] : r_idx + IDX_W'(1);
            end
            ST_MOVE: begin
                mem_we = 1'b1;
            end
            ST_DONE: begin
                out_load = !r_out_valid || !i_out_stall;
            end
            default: begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    tcps_pick #(
        .IDX_W (IDX_W)
    ) u_pick (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (pick_ctl),
        .i_entry    (r_rd_data),
        .i_idx      (r_idx),
        .i_arrival  (r_arrival),
        .o_best     (best),
        .o_best_idx (best_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_occ     <= '0;
            r_arrival <= '0;
            r_idx     <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_EXEC: begin
                    r_idx <= '0;
                    unique case (r_func)
                        FUNC_PUSH_READY, FUNC_PUSH_RESCHED: begin
                            if (!occ_full) begin
                                r_occ     <= r_occ + OCC_W'(1);
                                r_arrival <= r_arrival + STAMP_W'(1);
                            end
                        end
                        FUNC_FLUSH: begin
                            r_occ <= '0;
                        end
                        default: begin
                            r_occ <= r_occ;
                        end
                    endcase
                end
                ST_SCAN: begin
                    if (!scan_last) begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                ST_MOVE: begin
                    r_occ <= occ_m1;
                end
                default: begin
                    r_idx <= r_idx;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_func   <= t_func'(i_func);
            r_handle <= i_handle_id;
            r_class  <= i_queue_class;
            r_prio   <= i_prio_value;
        end
        if (r_state == ST_EXEC) begin
            r_res_served   <= 1'b0;
            r_res_handle   <= '0;
            r_res_source   <= KIND_NONE;
            r_res_rejected <= (r_func == FUNC_PUSH_READY || r_func == FUNC_PUSH_RESCHED)
                              && occ_full;
        end else if (r_state == ST_MOVE) begin
            r_res_served <= 1'b1;
            r_res_handle <= best.handle;
            r_res_source <= best.kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_served        <= r_res_served;
            r_served_handle <= r_res_handle;
            r_served_source <= r_res_source;
            r_push_rejected <= r_res_rejected;
            r_occupancy     <= occ_ext[OUT_OCC_W-1:0];
        end
    end

    assign o_in_stall      = in_stall;
    assign o_out_valid     = r_out_valid;
    assign o_served        = r_served;
    assign o_served_handle = r_served_handle;
    assign o_served_source = r_served_source;
    assign o_push_rejected = r_push_rejected;
    assign o_occupancy     = r_occupancy;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> OCC_W'(r_idx) < r_occ)
        else $error("scan index beyond stored entries");

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE && r_res_rejected |-> occ_full)
        else $error("push rejected with free space");

    a_move_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MOVE |=> r_occ == $past(r_occ) - OCC_W'(1))
        else $error("take did not release one entry");

    a_served_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE && r_res_served |-> r_res_source != KIND_NONE)
        else $error("served word without a source class");

endmodule

// ===== dv/tb_three_class_priority_fifo_scheduler_core.sv =====
// Self-checking testbench for the three-class priority scheduler store core.
module tb_three_class_priority_fifo_scheduler_core;
    import tcps_pkg::*;

    localparam int SLOTS          = 16;
    localparam int ITEMS_PER_PASS = 380;
    localparam int SETTLE_CYCLES  = 40;
    localparam int QUIET_LIMIT    = 4000;

    typedef struct packed {
        logic                 served;
        logic [HANDLE_W-1:0]  handle;
        logic [KIND_W-1:0]    source;
        logic                 rejected;
        logic [OUT_OCC_W-1:0] occupancy;
    } t_sched_result;

    class sched_scoreboard;
        logic [HANDLE_W-1:0] slot_handle [SLOTS];
        logic [KIND_W-1:0]   slot_kind [SLOTS];
        logic [PRIO_W-1:0]   slot_prio [SLOTS];
        logic [STAMP_W-1:0]  slot_stamp [SLOTS];
        bit                  slot_used [SLOTS];
        logic [STAMP_W-1:0]  push_count = '0;
        t_sched_result       expected_q [$];
        int                  errors = 0;

        task report(string msg);
            $display("ERROR %0t: %s", $time, msg);
            errors++;
        endtask

        function int stored();
            int n;
            n = 0;
            foreach (slot_used[i]) if (slot_used[i]) n++;
            return n;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Class first, then priority for rescheduled handles, then age.
        function bit outranks(int a, int b);
            logic [STAMP_W-1:0] age_a;
            logic [STAMP_W-1:0] age_b;
            age_a = push_count - slot_stamp[a];
            age_b = push_count - slot_stamp[b];
            if (slot_kind[a] != slot_kind[b]) return slot_kind[a] < slot_kind[b];
            if (slot_kind[a] != KIND_READY && slot_prio[a] != slot_prio[b])
                return slot_prio[a] < slot_prio[b];
            return age_a > age_b;
        endfunction

        function void note_input(t_func func, logic [HANDLE_W-1:0] handle,
                                 logic qclass, logic [PRIO_W-1:0] prio);
            t_sched_result r;
            int            slot;
            int            best;
            int            n;
            r    = '0;
            slot = -1;
            best = -1;
            case (func)
                FUNC_PUSH_READY, FUNC_PUSH_RESCHED: begin
                    for (int i = 0; i < SLOTS; i++)
                        if (!slot_used[i] && slot < 0) slot = i;
                    if (slot < 0) begin
                        r.rejected = 1'b1;
                    end else begin
                        slot_handle[slot] = handle;
                        if (func == FUNC_PUSH_READY) begin
                            slot_kind[slot] = KIND_READY;
                            slot_prio[slot] = '0;
                        end else begin
                            slot_kind[slot] = (qclass == CLASS_STD) ? KIND_DEFAULT
                                                                    : KIND_NOPIO;
                            slot_prio[slot] = prio;
                        end
                        slot_stamp[slot] = push_count;
                        slot_used[slot]  = 1'b1;
                        push_count       = push_count + 1'b1;
                    end
                end
                FUNC_TAKE: begin
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_used[i] && (best < 0 || outranks(i, best))) best = i;
                    if (best >= 0) begin
                        r.served        = 1'b1;
                        r.handle        = slot_handle[best];
                        r.source        = slot_kind[best];
                        slot_used[best] = 1'b0;
                    end
                end
                default: begin
                    foreach (slot_used[i]) slot_used[i] = 1'b0;
                end
            endcase
            n           = stored();
            r.occupancy = n[OUT_OCC_W-1:0];
            expected_q.push_back(r);
        endfunction

        task check_result(logic served, logic [HANDLE_W-1:0] handle,
                          logic [KIND_W-1:0] source, logic rejected,
                          logic [OUT_OCC_W-1:0] occupancy);
            t_sched_result want;
            if (expected_q.size() == 0) begin
                report("result word with nothing expected");
                return;
            end
            want = expected_q.pop_front();
            if (served !== want.served)
                report($sformatf("served got %b want %b", served, want.served));
            if (handle !== want.handle)
                report($sformatf("served_handle got %h want %h", handle, want.handle));
            if (source !== want.source)
                report($sformatf("served_source got %0d want %0d", source, want.source));
            if (rejected !== want.rejected)
                report($sformatf("push_rejected got %b want %b", rejected, want.rejected));
            if (occupancy !== want.occupancy)
                report($sformatf("occupancy got %0d want %0d", occupancy, want.occupancy));
        endtask
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic [1:0]           i_func        = '0;
    logic [HANDLE_W-1:0]  i_handle_id   = '0;
    logic                 i_queue_class = 1'b0;
    logic [PRIO_W-1:0]    i_prio_value  = '0;
    logic                 i_out_stall   = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_served;
    logic [HANDLE_W-1:0]  o_served_handle;
    logic [KIND_W-1:0]    o_served_source;
    logic                 o_push_rejected;
    logic [OUT_OCC_W-1:0] o_occupancy;

    sched_scoreboard sb = new();
    int              idle_pct    = 0;
    int              stall_pct   = 0;
    int              quiet_count = 0;

    three_class_priority_fifo_scheduler_core #(.CAPACITY(SLOTS)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_handle_id     (i_handle_id),
        .i_queue_class   (i_queue_class),
        .i_prio_value    (i_prio_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_served        (o_served),
        .o_served_handle (o_served_handle),
        .o_served_source (o_served_source),
        .o_push_rejected (o_push_rejected),
        .o_occupancy     (o_occupancy)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_input(t_func'(i_func), i_handle_id, i_queue_class, i_prio_value);
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_served, o_served_handle, o_served_source,
                            o_push_rejected, o_occupancy);
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
    end

    initial begin
        wait (quiet_count >= QUIET_LIMIT);
        $display("tb_three_class_priority_fifo_scheduler_core NOT OK");
        $finish;
    end

    task automatic drive_word(t_func func, logic [HANDLE_W-1:0] handle, logic qclass,
                              logic [PRIO_W-1:0] prio);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= func;
        i_handle_id   <= handle;
        i_queue_class <= qclass;
        i_prio_value  <= prio;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Alternate fill and drain spells; flush now and then.
    task automatic drive_random(int count);
        bit                filling;
        int                roll;
        int                push_pct;
        t_func             func;
        logic [PRIO_W-1:0] prio;
        filling = 1'b1;
        for (int n = 0; n < count; n++) begin
            if (sb.stored() >= SLOTS && $urandom_range(2) == 0) filling = 1'b0;
            if (sb.stored() == 0) filling = 1'b1;
            if ($urandom_range(99) < 3) filling = !filling;
            push_pct = filling ? 75 : 25;
            roll     = $urandom_range(99);
            if (roll < 2)
                func = FUNC_FLUSH;
            else if (roll < 2 + push_pct)
                func = ($urandom_range(1) == 0) ? FUNC_PUSH_READY : FUNC_PUSH_RESCHED;
            else
                func = FUNC_TAKE;
            roll = $urandom_range(99);
            if (roll < 40)
                prio = $urandom_range(7);
            else if (roll < 50)
                prio = ($urandom_range(1) == 0) ? '0 : '1;
            else
                prio = $urandom;
            drive_word(func, HANDLE_W'($urandom), 1'($urandom_range(1)), prio);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        drive_word(FUNC_TAKE, 16'hFFFF, CLASS_NOIO, '1);
        drive_word(FUNC_PUSH_READY, 16'h0000, CLASS_NOIO, '1);
        drive_word(FUNC_PUSH_READY, 16'hFFFF, CLASS_STD, '0);
        drive_word(FUNC_PUSH_RESCHED, 16'h1111, CLASS_STD, '1);
        drive_word(FUNC_PUSH_RESCHED, 16'h2222, CLASS_STD, '0);
        drive_word(FUNC_PUSH_RESCHED, 16'h3333, CLASS_NOIO, '0);
        drive_word(FUNC_PUSH_RESCHED, 16'h4444, CLASS_NOIO, 32'd5);
        drive_word(FUNC_PUSH_RESCHED, 16'h5555, CLASS_NOIO, 32'd5);
        drive_word(FUNC_PUSH_RESCHED, 16'h6666, CLASS_STD, '0);
        repeat (3) drive_word(FUNC_TAKE, 16'hA5A5, CLASS_NOIO, 32'h5A5A_5A5A);
        // fill to capacity, then push into the full store
        for (int i = 0; i < 10; i++)
            drive_word((i % 2 == 0) ? FUNC_PUSH_RESCHED : FUNC_PUSH_READY,
                       HANDLE_W'($urandom), 1'(i / 2 % 2), 32'h8000_0000);
        drive_word(FUNC_PUSH_READY, 16'hBEEF, CLASS_STD, '0);
        drive_word(FUNC_PUSH_RESCHED, 16'hCAFE, CLASS_STD, '0);
        drive_word(FUNC_FLUSH, 16'h1234, CLASS_NOIO, '1);
        drive_word(FUNC_TAKE, 16'h0000, CLASS_STD, '0);

        drive_random(ITEMS_PER_PASS);
        idle_pct = 83;
        drive_random(ITEMS_PER_PASS);
        idle_pct  = 0;
        stall_pct = 83;
        drive_random(ITEMS_PER_PASS);
        idle_pct  = 18;
        stall_pct = 18;
        drive_random(ITEMS_PER_PASS);
        idle_pct  = 0;
        stall_pct = 0;
        drive_random(ITEMS_PER_PASS);
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb_three_class_priority_fifo_scheduler_core OK");
        else
            $display("tb_three_class_priority_fifo_scheduler_core NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
src/tcps_pkg.sv
src/tcps_pick.sv
src/three_class_priority_fifo_scheduler_core.sv
dv/tb_three_class_priority_fifo_scheduler_core.sv
